/* hdl/dhcprp_pkg.sv */
// shared types and constants for the dhcp reply parser
package dhcprp_pkg;

  localparam int MAC_BYTES     = 6;
  localparam int OPTIONS_START = 240;

  localparam int OFFSET_W   = 10;
  localparam int MAC_FIRST  = 28;
  localparam int MAC_LAST   = MAC_FIRST + MAC_BYTES - 1;
  localparam int CFG_MAC_BYTES = 6;

  localparam logic [OFFSET_W-1:0] OFFSET_MAX = {OFFSET_W{1'b1}};

  localparam logic [31:0] TID_RESET = 32'hADDE1223;

  // header bytes
  localparam logic [7:0] OP_REPLY = 8'd2;

  // option codes
  localparam logic [7:0] OPT_PAD      = 8'd0;
  localparam logic [7:0] OPT_SUBNET   = 8'd1;
  localparam logic [7:0] OPT_ROUTER   = 8'd3;
  localparam logic [7:0] OPT_DNS      = 8'd6;
  localparam logic [7:0] OPT_LEASE    = 8'd51;
  localparam logic [7:0] OPT_MSG_TYPE = 8'd53;
  localparam logic [7:0] OPT_SERVER   = 8'd54;
  localparam logic [7:0] OPT_END      = 8'd255;

  // configuration register indexes
  localparam int CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] CFG_CLIENT_MAC     = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TRANSACTION_ID = 8'd1;

  // held field slots
  localparam int H_OFFER  = 0;
  localparam int H_SUBNET = 1;
  localparam int H_ROUTER = 2;
  localparam int H_DNS    = 3;
  localparam int H_SERVER = 4;
  localparam int H_LEASE  = 5;
  localparam int H_COUNT  = 6;

  localparam int OUT_DATA_W = 208;

  typedef enum logic [1:0] {
    PH_CODE,
    PH_LEN,
    PH_VALUE
  } phase_t;

  typedef struct packed {
    logic        header_ok;
    logic [7:0]  message_type;
    logic [31:0] offered_ip;
    logic [31:0] subnet_mask;
    logic [31:0] gateway_ip;
    logic [31:0] name_server_ip;
    logic [31:0] server_ident;
    logic [31:0] lease_seconds;
  } result_t;

endpackage

/* hdl/dhcprp_parse.sv */
// per-message parse state: header match, option walk and held fields
module dhcprp_parse import dhcprp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [7:0]  msg_byte,
  input  logic        last_byte,
  input  logic [47:0] client_mac,
  input  logic [31:0] transaction_id,
  output result_t     result
);

  logic [OFFSET_W-1:0] byte_offset, byte_offset_next;
  logic                header_match, header_match_next;
  logic [31:0]         staged_offer, staged_offer_next;
  phase_t              option_phase, option_phase_next;
  logic [7:0]          option_code, option_code_next;
  logic [7:0]          option_length, option_length_next;
  logic [7:0]          value_remaining, value_remaining_next;
  logic [31:0]         value_shift, value_shift_next;
  logic                options_done, options_done_next;
  logic [7:0]          type_seen, type_seen_next;
  logic [31:0]         held [H_COUNT];
  logic [31:0]         held_next [H_COUNT];

  logic                in_options;
  logic [7:0]          value_idx;
  logic [7:0]          remaining_dec;
  logic [OFFSET_W-1:0] mac_pos;
  logic [7:0]          mac_want;
  logic [7:0]          tid_want;
  logic                ok;

  assign in_options    = (byte_offset >= OFFSET_W'(OPTIONS_START)) && !options_done;
  assign value_idx     = option_length - value_remaining;
  assign remaining_dec = value_remaining - 8'd1;
  assign mac_pos       = OFFSET_W'(MAC_LAST) - byte_offset;
  assign tid_want      = transaction_id[{~byte_offset[1:0], 3'b000} +: 8];

  always_comb begin
    mac_want = '0;
    if (mac_pos < OFFSET_W'(CFG_MAC_BYTES)) begin
      case (mac_pos[2:0])
        3'd0:    mac_want = client_mac[7:0];
        3'd1:    mac_want = client_mac[15:8];
        3'd2:    mac_want = client_mac[23:16];
        3'd3:    mac_want = client_mac[31:24];
        3'd4:    mac_want = client_mac[39:32];
        3'd5:    mac_want = client_mac[47:40];
        default: mac_want = '0;
      endcase
    end
  end

  // option walk phase
  always_comb begin
    option_phase_next = option_phase;
    if (in_options) begin
      case (option_phase)
        PH_CODE: begin
          if (msg_byte != OPT_END && msg_byte != OPT_PAD) option_phase_next = PH_LEN;
        end
        PH_LEN: begin
          option_phase_next = (msg_byte == 8'd0) ? PH_CODE : PH_VALUE;
        end
        PH_VALUE: begin
          if (remaining_dec == 8'd0) option_phase_next = PH_CODE;
        end
        default: option_phase_next = PH_CODE;
      endcase
    end
  end

  // header checks, option values and captures
  always_comb begin
    header_match_next    = header_match;
    staged_offer_next    = staged_offer;
    option_code_next     = option_code;
    option_length_next   = option_length;
    value_remaining_next = value_remaining;
    value_shift_next     = value_shift;
    options_done_next    = options_done;
    type_seen_next       = type_seen;
    for (int i = 0; i < H_COUNT; i++) held_next[i] = held[i];

    if (byte_offset == '0 && msg_byte != OP_REPLY) header_match_next = 1'b0;
    if (byte_offset >= OFFSET_W'(4) && byte_offset <= OFFSET_W'(7) && tid_want != msg_byte)
      header_match_next = 1'b0;
    if (byte_offset >= OFFSET_W'(16) && byte_offset <= OFFSET_W'(19))
      staged_offer_next = {staged_offer[23:0], msg_byte};
    if (byte_offset >= OFFSET_W'(MAC_FIRST) && byte_offset <= OFFSET_W'(MAC_LAST) &&
        mac_want != msg_byte)
      header_match_next = 1'b0;

    if (in_options) begin
      case (option_phase)
        PH_CODE: begin
          if (msg_byte == OPT_END) options_done_next = 1'b1;
          else if (msg_byte != OPT_PAD) option_code_next = msg_byte;
        end
        PH_LEN: begin
          option_length_next   = msg_byte;
          value_remaining_next = msg_byte;
          value_shift_next     = '0;
        end
        PH_VALUE: begin
          if (value_idx < 8'd4) value_shift_next = {value_shift[23:0], msg_byte};
          if (header_match_next) begin
            if (option_code == OPT_MSG_TYPE && value_idx == 8'd0) type_seen_next = msg_byte;
            if (value_idx == 8'd3) begin
              case (option_code)
                OPT_SUBNET: held_next[H_SUBNET] = value_shift_next;
                OPT_ROUTER: held_next[H_ROUTER] = value_shift_next;
                OPT_DNS:    held_next[H_DNS]    = value_shift_next;
                OPT_SERVER: held_next[H_SERVER] = value_shift_next;
                OPT_LEASE:  held_next[H_LEASE]  = value_shift_next;
                default:    ;
              endcase
            end
          end
          value_remaining_next = remaining_dec;
        end
        default: ;
      endcase
    end

    // too short a message never reaches the whole hardware address
    ok = header_match_next && (byte_offset >= OFFSET_W'(MAC_LAST));
    if (last_byte && ok) held_next[H_OFFER] = staged_offer_next;

    byte_offset_next = (byte_offset == OFFSET_MAX) ? byte_offset : byte_offset + 1'b1;
  end

  always_comb begin
    result.header_ok      = ok;
    result.message_type   = ok ? type_seen_next : 8'd0;
    result.offered_ip     = held_next[H_OFFER];
    result.subnet_mask    = held_next[H_SUBNET];
    result.gateway_ip     = held_next[H_ROUTER];
    result.name_server_ip = held_next[H_DNS];
    result.server_ident   = held_next[H_SERVER];
    result.lease_seconds  = held_next[H_LEASE];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset     <= '0;
      header_match    <= 1'b1;
      staged_offer    <= '0;
      option_phase    <= PH_CODE;
      option_code     <= '0;
      option_length   <= '0;
      value_remaining <= '0;
      value_shift     <= '0;
      options_done    <= 1'b0;
      type_seen       <= '0;
      for (int i = 0; i < H_COUNT; i++) held[i] <= '0;
    end else if (step) begin
      for (int i = 0; i < H_COUNT; i++) held[i] <= held_next[i];
      if (last_byte) begin
        // start of the next message
        byte_offset     <= '0;
        header_match    <= 1'b1;
        staged_offer    <= '0;
        option_phase    <= PH_CODE;
        option_code     <= '0;
        option_length   <= '0;
        value_remaining <= '0;
        value_shift     <= '0;
        options_done    <= 1'b0;
        type_seen       <= '0;
      end else begin
        byte_offset     <= byte_offset_next;
        header_match    <= header_match_next;
        staged_offer    <= staged_offer_next;
        option_phase    <= option_phase_next;
        option_code     <= option_code_next;
        option_length   <= option_length_next;
        value_remaining <= value_remaining_next;
        value_shift     <= value_shift_next;
        options_done    <= options_done_next;
        type_seen       <= type_seen_next;
      end
    end
  end

endmodule

/* hdl/dhcp_reply_parser.sv */
// dhcp reply parser top level: input register, parse state, result register
// a result goes from the input register through the parse logic into the result register once its last word is accepted
// throughput: one word per cycle; a waiting result stalls the input only on a last word
// the whole step for a word is the parse logic between input and result registers
// reset: synchronous; clears held fields and message state, loads the config defaults
module dhcp_reply_parser import dhcprp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,   // msg_byte
  input  logic                   s_axis_tlast,   // last_byte
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // header_ok, message_type, offered_ip, subnet_mask, gateway_ip,
  // name_server_ip, server_ident, lease_seconds, zero fill
  output logic [OUT_DATA_W-1:0]  m_axis_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [47:0]            cfg_data
);

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_last;
  logic        out_free;
  logic        advance;
  logic [47:0] client_mac;
  logic [31:0] transaction_id;
  result_t     result;
  result_t     out_result;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign advance       = in_valid && (!in_last || out_free);
  assign s_axis_tready = !in_valid || advance;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      client_mac     <= '0;
      transaction_id <= TID_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CLIENT_MAC:     client_mac     <= cfg_data;
        CFG_TRANSACTION_ID: transaction_id <= cfg_data[31:0];
        default:            ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  dhcprp_parse u_parse (
    .clk            (clk),
    .rst            (rst),
    .step           (advance),
    .msg_byte       (in_byte),
    .last_byte      (in_last),
    .client_mac     (client_mac),
    .transaction_id (transaction_id),
    .result         (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= advance && in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) out_result <= result;
  end

  assign m_axis_tdata = {7'd0,
                         out_result.lease_seconds,
                         out_result.server_ident,
                         out_result.name_server_ip,
                         out_result.gateway_ip,
                         out_result.subnet_mask,
                         out_result.offered_ip,
                         out_result.message_type,
                         out_result.header_ok};

endmodule

/* hdl/dhcprp_checker.sv */
// port checks for the dhcp reply parser, bound to the top level
module dhcprp_checker import dhcprp_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [7:0]             s_axis_tdata,
  input logic                   s_axis_tlast,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_DATA_W-1:0]  m_axis_tdata,
  input logic                   cfg_valid,
  input logic                   cfg_ready,
  input logic [CFG_INDEX_W-1:0] cfg_index,
  input logic [47:0]            cfg_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // no message type without a matched header
  a_type_needs_match: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[8:1] == 8'd0)
    else $error("message type reported on header mismatch");

  // input only waits behind a pending result
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with no pending result");

  // reset leaves no result behind
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind dhcp_reply_parser dhcprp_checker u_dhcprp_checker (.*);
